>>> sv/qs_pkg.sv
// Shared types, constants and the arctangent table of the quaternion slerp unit.
package qs_pkg;

   localparam int ATAN_ENTRIES = 24;
   localparam int SQRT_BITS    = 29;
   localparam int DIV_BITS     = 31;

   localparam logic signed [33:0] ONE_Q28      = 34'sd268435456;
   localparam logic signed [34:0] EPS_Q28      = 35'sd26844;
   localparam logic        [15:0] BLEND_ONE    = 16'h8000;
   localparam logic        [31:0] HALF_TURN    = 32'h8000_0000;
   localparam logic        [31:0] QUARTER_TURN = 32'h4000_0000;
   localparam logic        [30:0] WEIGHT_MAX   = 31'h7FFF_FFFF;

   localparam logic [31:0] ATAN_TAB [ATAN_ENTRIES] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
      32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
      32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
   };

   typedef logic [3:0][15:0] quad_type;

   typedef struct packed {
      logic signed [15:0] first_x;
      logic signed [15:0] first_y;
      logic signed [15:0] first_z;
      logic signed [15:0] first_w;
      logic signed [15:0] second_x;
      logic signed [15:0] second_y;
      logic signed [15:0] second_z;
      logic signed [15:0] second_w;
      logic        [15:0] blend;
   } req_payload_type;

   typedef struct packed {
      logic signed [15:0] out_x;
      logic signed [15:0] out_y;
      logic signed [15:0] out_z;
      logic signed [15:0] out_w;
      logic               near_equal;
   } rsp_payload_type;

   typedef struct packed {
      quad_type qa;
      quad_type qb;
      logic     near;
   } mid_side_type;

   typedef struct packed {
      mid_side_type mid;
      logic [15:0]  blend;
   } pre_side_type;

   typedef struct packed {
      pre_side_type       pre;
      logic signed [29:0] cos_val;
   } root_side_type;

endpackage

>>> sv/qs_chan_if.sv
// Valid/ready channel carrying one payload struct.
interface qs_chan_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

>>> sv/qs_isqrt.sv
// Pipelined floor square root, one result bit per stage.
module qs_isqrt #(
   parameter int SIDE_W = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic [56:0]                   rad_in,
   input  logic [SIDE_W-1:0]             side_in,
   output logic                          out_valid,
   output logic [qs_pkg::SQRT_BITS-1:0]  root_out,
   output logic [SIDE_W-1:0]             side_out
);
   import qs_pkg::*;

   logic                 vld_ff  [SQRT_BITS];
   logic [56:0]          rem_ff  [SQRT_BITS];
   logic [SQRT_BITS-1:0] root_ff [SQRT_BITS];
   logic [SIDE_W-1:0]    side_ff [SQRT_BITS];

   for (genvar j = 0; j < SQRT_BITS; j++) begin : g_stage
      logic                 vld_prev;
      logic [56:0]          rem_prev;
      logic [SQRT_BITS-1:0] root_prev;
      logic [SIDE_W-1:0]    side_prev;
      logic [57:0]          trial;
      logic                 take;

      if (j == 0) begin : g_first
         assign vld_prev  = in_valid;
         assign rem_prev  = rad_in;
         assign root_prev = '0;
         assign side_prev = side_in;
      end else begin : g_next
         assign vld_prev  = vld_ff[j-1];
         assign rem_prev  = rem_ff[j-1];
         assign root_prev = root_ff[j-1];
         assign side_prev = side_ff[j-1];
      end

      // root holds only bits above this one, so 2*root*2^i + 4^i is a plain OR
      assign trial = ({{(58-SQRT_BITS){1'b0}}, root_prev} << (SQRT_BITS - j))
                   | (58'd1 << (2 * (SQRT_BITS - 1 - j)));
      assign take  = {1'b0, rem_prev} >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[j] <= 1'b0;
         end else if (en) begin
            vld_ff[j] <= vld_prev;
         end
         if (en) begin
            rem_ff[j]  <= take ? (rem_prev - trial[56:0]) : rem_prev;
            root_ff[j] <= take ? (root_prev | (SQRT_BITS'(1) << (SQRT_BITS - 1 - j)))
                               : root_prev;
            side_ff[j] <= side_prev;
         end
      end
   end

   assign out_valid = vld_ff[SQRT_BITS-1];
   assign root_out  = root_ff[SQRT_BITS-1];
   assign side_out  = side_ff[SQRT_BITS-1];

endmodule

>>> sv/qs_vector.sv
// Vectoring CORDIC pipeline: angle of (c, s) in binary angle units, clamped to [0, pi].
module qs_vector #(
   parameter int STEPS  = 16,
   parameter int SIDE_W = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  logic signed [29:0]  cos_in,
   input  logic [28:0]         sin_in,
   input  logic [SIDE_W-1:0]   side_in,
   output logic                out_valid,
   output logic [31:0]         angle_out,
   output logic [SIDE_W-1:0]   side_out
);
   import qs_pkg::*;

   localparam logic signed [33:0] HALF_Z = 34'sh0_8000_0000;

   logic               vld_ff  [STEPS];
   logic signed [31:0] x_ff    [STEPS];
   logic signed [31:0] y_ff    [STEPS];
   logic signed [33:0] z_ff    [STEPS];
   logic [SIDE_W-1:0]  side_ff [STEPS];

   logic signed [31:0] x_init;
   logic signed [31:0] y_init;
   logic signed [33:0] z_init;

   // left half plane: rotate by a quarter turn first
   always_comb begin
      if (!cos_in[29]) begin
         x_init = 32'(cos_in);
         y_init = $signed({3'b000, sin_in});
         z_init = '0;
      end else begin
         x_init = $signed({3'b000, sin_in});
         y_init = -32'(cos_in);
         z_init = $signed({2'b00, QUARTER_TURN});
      end
   end

   for (genvar g = 0; g < STEPS; g++) begin : g_stage
      logic               vld_prev;
      logic signed [31:0] x_prev;
      logic signed [31:0] y_prev;
      logic signed [33:0] z_prev;
      logic [SIDE_W-1:0]  side_prev;
      logic signed [33:0] atan_step;
      logic               y_pos;

      if (g == 0) begin : g_first
         assign vld_prev  = in_valid;
         assign x_prev    = x_init;
         assign y_prev    = y_init;
         assign z_prev    = z_init;
         assign side_prev = side_in;
      end else begin : g_next
         assign vld_prev  = vld_ff[g-1];
         assign x_prev    = x_ff[g-1];
         assign y_prev    = y_ff[g-1];
         assign z_prev    = z_ff[g-1];
         assign side_prev = side_ff[g-1];
      end

      assign atan_step = $signed({2'b00, ATAN_TAB[g]});
      assign y_pos     = y_prev > 32'sd0;

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[g] <= 1'b0;
         end else if (en) begin
            vld_ff[g] <= vld_prev;
         end
         if (en) begin
            x_ff[g]    <= y_pos ? (x_prev + (y_prev >>> g)) : (x_prev - (y_prev >>> g));
            y_ff[g]    <= y_pos ? (y_prev - (x_prev >>> g)) : (y_prev + (x_prev >>> g));
            z_ff[g]    <= y_pos ? (z_prev + atan_step) : (z_prev - atan_step);
            side_ff[g] <= side_prev;
         end
      end
   end

   always_comb begin
      if (z_ff[STEPS-1][33]) begin
         angle_out = '0;
      end else if (z_ff[STEPS-1] > HALF_Z) begin
         angle_out = HALF_TURN;
      end else begin
         angle_out = z_ff[STEPS-1][31:0];
      end
   end

   assign out_valid = vld_ff[STEPS-1];
   assign side_out  = side_ff[STEPS-1];

endmodule

>>> sv/qs_rotate.sv
// Three-lane rotation CORDIC pipeline: gain-scaled sines of angles in [0, pi].
module qs_rotate #(
   parameter int STEPS  = 16,
   parameter int SIDE_W = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  logic [2:0][31:0]   angle_in,
   input  logic [SIDE_W-1:0]  side_in,
   output logic               out_valid,
   output logic [2:0][29:0]   sine_out,
   output logic [SIDE_W-1:0]  side_out
);
   import qs_pkg::*;

   localparam logic signed [31:0] X_START = 32'sh1000_0000;

   logic               vld_ff  [STEPS];
   logic [SIDE_W-1:0]  side_ff [STEPS];
   logic signed [31:0] x_ff    [STEPS][3];
   logic signed [31:0] y_ff    [STEPS][3];
   logic signed [32:0] z_ff    [STEPS][3];

   for (genvar g = 0; g < STEPS; g++) begin : g_stage
      logic              vld_prev;
      logic [SIDE_W-1:0] side_prev;

      if (g == 0) begin : g_first
         assign vld_prev  = in_valid;
         assign side_prev = side_in;
      end else begin : g_next
         assign vld_prev  = vld_ff[g-1];
         assign side_prev = side_ff[g-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[g] <= 1'b0;
         end else if (en) begin
            vld_ff[g] <= vld_prev;
         end
         if (en) begin
            side_ff[g] <= side_prev;
         end
      end

      for (genvar l = 0; l < 3; l++) begin : g_lane
         logic signed [31:0] x_prev;
         logic signed [31:0] y_prev;
         logic signed [32:0] z_prev;
         logic signed [32:0] atan_step;
         logic               z_pos;

         if (g == 0) begin : g_first
            logic [31:0] folded;
            // fold the second quadrant onto the first
            assign folded = (angle_in[l] > QUARTER_TURN) ? (HALF_TURN - angle_in[l])
                                                         : angle_in[l];
            assign x_prev = X_START;
            assign y_prev = '0;
            assign z_prev = $signed({1'b0, folded});
         end else begin : g_next
            assign x_prev = x_ff[g-1][l];
            assign y_prev = y_ff[g-1][l];
            assign z_prev = z_ff[g-1][l];
         end

         assign atan_step = $signed({1'b0, ATAN_TAB[g]});
         assign z_pos     = !z_prev[32];

         always_ff @(posedge clock) begin
            if (en) begin
               x_ff[g][l] <= z_pos ? (x_prev - (y_prev >>> g)) : (x_prev + (y_prev >>> g));
               y_ff[g][l] <= z_pos ? (y_prev + (x_prev >>> g)) : (y_prev - (x_prev >>> g));
               z_ff[g][l] <= z_pos ? (z_prev - atan_step) : (z_prev + atan_step);
            end
         end
      end
   end

   for (genvar l = 0; l < 3; l++) begin : g_out
      // drop negative residues to zero
      assign sine_out[l] = y_ff[STEPS-1][l][31] ? 30'd0 : y_ff[STEPS-1][l][29:0];
   end

   assign out_valid = vld_ff[STEPS-1];
   assign side_out  = side_ff[STEPS-1];

endmodule

>>> sv/qs_divide.sv
// Two-lane restoring divider: saturated Q15.16 weights num * 2^16 / den.
module qs_divide #(
   parameter int SIDE_W = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  logic                              in_valid,
   input  logic [29:0]                       den_in,
   input  logic [1:0][29:0]                  num_in,
   input  logic [SIDE_W-1:0]                 side_in,
   output logic                              out_valid,
   output logic [1:0][qs_pkg::DIV_BITS-1:0]  weight_out,
   output logic [SIDE_W-1:0]                 side_out
);
   import qs_pkg::*;

   // classification stage
   logic                pre_vld_ff;
   logic [29:0]         pre_den_ff;
   logic [SIDE_W-1:0]   pre_side_ff;
   logic [29:0]         pre_rem_ff  [2];
   logic [DIV_BITS-1:0] pre_low_ff  [2];
   logic                pre_sat_ff  [2];
   logic                pre_zero_ff [2];

   logic                vld_ff  [DIV_BITS];
   logic [29:0]         den_ff  [DIV_BITS];
   logic [SIDE_W-1:0]   side_ff [DIV_BITS];
   logic [29:0]         rem_ff  [DIV_BITS][2];
   logic [DIV_BITS-1:0] low_ff  [DIV_BITS][2];
   logic [DIV_BITS-1:0] quo_ff  [DIV_BITS][2];
   logic                sat_ff  [DIV_BITS][2];
   logic                zero_ff [DIV_BITS][2];

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_vld_ff <= 1'b0;
      end else if (en) begin
         pre_vld_ff <= in_valid;
      end
      if (en) begin
         pre_den_ff  <= den_in;
         pre_side_ff <= side_in;
      end
   end

   for (genvar l = 0; l < 2; l++) begin : g_class
      logic den_zero;
      logic num_zero;
      logic too_big;

      assign den_zero = den_in == 30'd0;
      assign num_zero = num_in[l] == 30'd0;
      // quotient reaches 2^31 exactly when num >= den * 2^15
      assign too_big  = {15'd0, num_in[l]} >= {den_in, 15'd0};

      always_ff @(posedge clock) begin
         if (en) begin
            pre_rem_ff[l]  <= {15'd0, num_in[l][29:15]};
            pre_low_ff[l]  <= {num_in[l][14:0], 16'd0};
            pre_sat_ff[l]  <= den_zero ? !num_zero : too_big;
            pre_zero_ff[l] <= den_zero & num_zero;
         end
      end
   end

   for (genvar j = 0; j < DIV_BITS; j++) begin : g_stage
      logic              vld_prev;
      logic [29:0]       den_prev;
      logic [SIDE_W-1:0] side_prev;

      if (j == 0) begin : g_first
         assign vld_prev  = pre_vld_ff;
         assign den_prev  = pre_den_ff;
         assign side_prev = pre_side_ff;
      end else begin : g_next
         assign vld_prev  = vld_ff[j-1];
         assign den_prev  = den_ff[j-1];
         assign side_prev = side_ff[j-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[j] <= 1'b0;
         end else if (en) begin
            vld_ff[j] <= vld_prev;
         end
         if (en) begin
            den_ff[j]  <= den_prev;
            side_ff[j] <= side_prev;
         end
      end

      for (genvar l = 0; l < 2; l++) begin : g_lane
         logic [29:0]         rem_prev;
         logic [DIV_BITS-1:0] low_prev;
         logic [DIV_BITS-1:0] quo_prev;
         logic                sat_prev;
         logic                zero_prev;
         logic [30:0]         shifted;
         logic [30:0]         diff;
         logic                take;

         if (j == 0) begin : g_first
            assign rem_prev  = pre_rem_ff[l];
            assign low_prev  = pre_low_ff[l];
            assign quo_prev  = '0;
            assign sat_prev  = pre_sat_ff[l];
            assign zero_prev = pre_zero_ff[l];
         end else begin : g_next
            assign rem_prev  = rem_ff[j-1][l];
            assign low_prev  = low_ff[j-1][l];
            assign quo_prev  = quo_ff[j-1][l];
            assign sat_prev  = sat_ff[j-1][l];
            assign zero_prev = zero_ff[j-1][l];
         end

         assign shifted = {rem_prev, low_prev[DIV_BITS-1-j]};
         assign diff    = shifted - {1'b0, den_prev};
         assign take    = shifted >= {1'b0, den_prev};

         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[j][l]  <= take ? diff[29:0] : shifted[29:0];
               low_ff[j][l]  <= low_prev;
               quo_ff[j][l]  <= take ? (quo_prev | (DIV_BITS'(1) << (DIV_BITS - 1 - j)))
                                     : quo_prev;
               sat_ff[j][l]  <= sat_prev;
               zero_ff[j][l] <= zero_prev;
            end
         end
      end
   end

   for (genvar l = 0; l < 2; l++) begin : g_out
      always_comb begin
         if (zero_ff[DIV_BITS-1][l]) begin
            weight_out[l] = '0;
         end else if (sat_ff[DIV_BITS-1][l]) begin
            weight_out[l] = WEIGHT_MAX;
         end else begin
            weight_out[l] = quo_ff[DIV_BITS-1][l];
         end
      end
   end

   assign out_valid = vld_ff[DIV_BITS-1];
   assign side_out  = side_ff[DIV_BITS-1];

endmodule

>>> sv/quaternion_slerp.sv
// Top level of the quaternion slerp unit: dot product, angle, sines, weights and blend.
//
//   channel    direction  payload                                   handshake
//   req_chan   in         first_x..w, second_x..w (Q2.14), blend    valid/ready
//   rsp_chan   out        out_x..w (Q2.14, saturated), near_equal   valid/ready
//
// Takes one transfer per cycle unless the result register stalls; the depth is set by the
// 29 square-root stages, the two CORDIC chains and the 31 divider stages.
// Reset clears every valid bit of the pipeline and the result register.
// All stages share one advance enable; it stays high while the result register is
// free, is being drained, or the last stage holds a bubble, so bubbles close up.
module quaternion_slerp #(
   parameter int ANGLE_STEPS = 16
) (
   input  logic         clock,
   input  logic         reset,
   qs_chan_if.sink      req_chan,
   qs_chan_if.source    rsp_chan
);
   import qs_pkg::*;

   localparam int ROOT_SIDE_W = $bits(root_side_type);
   localparam int PRE_SIDE_W  = $bits(pre_side_type);
   localparam int MID_SIDE_W  = $bits(mid_side_type);

   logic en;

   // ---------------------------------------------------------------- stage A
   // form the four component products, clamp the blend factor
   req_payload_type    req_data;
   quad_type           qa_in;
   quad_type           qb_in;
   logic               a_vld_ff;
   logic signed [31:0] prod_ff [4];
   pre_side_type       a_side_ff;
   pre_side_type       a_side_in;

   assign req_data = req_chan.data;
   assign qa_in    = {req_data.first_w, req_data.first_z, req_data.first_y, req_data.first_x};
   assign qb_in    = {req_data.second_w, req_data.second_z, req_data.second_y,
                      req_data.second_x};

   always_comb begin
      a_side_in.mid.qa   = qa_in;
      a_side_in.mid.qb   = qb_in;
      a_side_in.mid.near = 1'b0;
      a_side_in.blend    = (req_data.blend > BLEND_ONE) ? BLEND_ONE : req_data.blend;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else if (en) begin
         a_vld_ff <= req_chan.valid;
      end
      if (en) begin
         for (int k = 0; k < 4; k++) begin
            prod_ff[k] <= $signed(qa_in[k]) * $signed(qb_in[k]);
         end
         a_side_ff <= a_side_in;
      end
   end

   // ---------------------------------------------------------------- stage B
   // sum the dot product, test for near alignment, clamp to [-1, 1]
   logic signed [33:0] dot_sum;
   logic signed [34:0] dot_diff;
   logic signed [34:0] dot_dist;
   logic signed [33:0] dot_clamp;
   logic signed [29:0] cos_in;
   logic [28:0]        cmag_in;
   logic               b_vld_ff;
   logic signed [29:0] cos_ff;
   logic [28:0]        cmag_ff;
   pre_side_type       b_side_ff;
   pre_side_type       b_side_in;

   assign dot_sum  = 34'(prod_ff[0]) + 34'(prod_ff[1]) + 34'(prod_ff[2]) + 34'(prod_ff[3]);
   assign dot_diff = 35'(ONE_Q28) - 35'(dot_sum);
   assign dot_dist = dot_diff[34] ? -dot_diff : dot_diff;

   always_comb begin
      if (dot_sum > ONE_Q28) begin
         dot_clamp = ONE_Q28;
      end else if (dot_sum < -ONE_Q28) begin
         dot_clamp = -ONE_Q28;
      end else begin
         dot_clamp = dot_sum;
      end
      cos_in  = 30'(dot_clamp);
      cmag_in = cos_in[29] ? 29'(-cos_in) : 29'(cos_in);
      b_side_in          = a_side_ff;
      b_side_in.mid.near = dot_dist < EPS_Q28;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
      end else if (en) begin
         b_vld_ff <= a_vld_ff;
      end
      if (en) begin
         cos_ff    <= cos_in;
         cmag_ff   <= cmag_in;
         b_side_ff <= b_side_in;
      end
   end

   // ---------------------------------------------------------------- stage C
   // radicand 1 - c^2 in Q.56
   logic [57:0]   cos_sq;
   logic [57:0]   rad_full;
   logic          c_vld_ff;
   logic [56:0]   rad_ff;
   root_side_type c_side_ff;

   assign cos_sq   = cmag_ff * cmag_ff;
   assign rad_full = 58'h100000000000000 - cos_sq;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_vld_ff <= 1'b0;
      end else if (en) begin
         c_vld_ff <= b_vld_ff;
      end
      if (en) begin
         rad_ff            <= rad_full[56:0];
         c_side_ff.pre     <= b_side_ff;
         c_side_ff.cos_val <= cos_ff;
      end
   end

   // ---------------------------------------------------------------- sqrt
   logic                 sq_vld;
   logic [SQRT_BITS-1:0] sq_root;
   root_side_type        sq_side;

   qs_isqrt #(
      .SIDE_W    (ROOT_SIDE_W)
   ) u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (c_vld_ff),
      .rad_in    (rad_ff),
      .side_in   (c_side_ff),
      .out_valid (sq_vld),
      .root_out  (sq_root),
      .side_out  (sq_side)
   );

   // ---------------------------------------------------------------- omega
   logic         vec_vld;
   logic [31:0]  omega;
   pre_side_type vec_side;

   qs_vector #(
      .STEPS     (ANGLE_STEPS),
      .SIDE_W    (PRE_SIDE_W)
   ) u_vector (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sq_vld),
      .cos_in    (sq_side.cos_val),
      .sin_in    (sq_root),
      .side_in   (sq_side.pre),
      .out_valid (vec_vld),
      .angle_out (omega),
      .side_out  (vec_side)
   );

   // ---------------------------------------------------------------- stage M
   // t * omega, rounded half up
   logic [47:0]  blend_prod;
   logic [47:0]  blend_rnd;
   logic         m_vld_ff;
   logic [31:0]  omega_ff;
   logic [31:0]  part_ff;
   mid_side_type m_side_ff;

   assign blend_prod = 48'(omega) * 48'(vec_side.blend);
   assign blend_rnd  = (blend_prod + 48'd16384) >> 15;

   always_ff @(posedge clock) begin
      if (reset) begin
         m_vld_ff <= 1'b0;
      end else if (en) begin
         m_vld_ff <= vec_vld;
      end
      if (en) begin
         omega_ff  <= omega;
         part_ff   <= blend_rnd[31:0];
         m_side_ff <= vec_side.mid;
      end
   end

   // ---------------------------------------------------------------- sines
   // lane 0: sin(omega), lane 1: sin((1-t)omega), lane 2: sin(t omega)
   logic [2:0][31:0] angles;
   logic             rot_vld;
   logic [2:0][29:0] sines;
   mid_side_type     rot_side;

   assign angles = {part_ff, omega_ff - part_ff, omega_ff};

   qs_rotate #(
      .STEPS     (ANGLE_STEPS),
      .SIDE_W    (MID_SIDE_W)
   ) u_rotate (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (m_vld_ff),
      .angle_in  (angles),
      .side_in   (m_side_ff),
      .out_valid (rot_vld),
      .sine_out  (sines),
      .side_out  (rot_side)
   );

   // ---------------------------------------------------------------- weights
   logic                      div_vld;
   logic [1:0][DIV_BITS-1:0]  weights;
   mid_side_type              div_side;

   qs_divide #(
      .SIDE_W     (MID_SIDE_W)
   ) u_divide (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_valid   (rot_vld),
      .den_in     (sines[0]),
      .num_in     ({sines[2], sines[1]}),
      .side_in    (rot_side),
      .out_valid  (div_vld),
      .weight_out (weights),
      .side_out   (div_side)
   );

   // ---------------------------------------------------------------- stage P
   // weight each component
   logic               p_vld_ff;
   logic signed [47:0] p1_ff [4];
   logic signed [47:0] p2_ff [4];
   mid_side_type       p_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p_vld_ff <= 1'b0;
      end else if (en) begin
         p_vld_ff <= div_vld;
      end
      if (en) begin
         for (int k = 0; k < 4; k++) begin
            p1_ff[k] <= $signed({1'b0, weights[0]}) * $signed(div_side.qa[k]);
            p2_ff[k] <= $signed({1'b0, weights[1]}) * $signed(div_side.qb[k]);
         end
         p_side_ff <= div_side;
      end
   end

   // ---------------------------------------------------------------- result register
   // sum, round, saturate; pass the first quaternion through when nearly aligned
   logic              out_free;
   logic              rsp_vld_ff;
   rsp_payload_type   rsp_data_ff;
   logic [3:0][15:0]  comp;
   rsp_payload_type   rsp_data_in;

   for (genvar k = 0; k < 4; k++) begin : g_comp
      logic signed [48:0] acc;
      logic signed [48:0] rnd;

      assign acc = 49'(p1_ff[k]) + 49'(p2_ff[k]);
      assign rnd = (acc + 49'sd32768) >>> 16;

      always_comb begin
         if (p_side_ff.near) begin
            comp[k] = p_side_ff.qa[k];
         end else if (rnd > 49'sd32767) begin
            comp[k] = 16'h7FFF;
         end else if (rnd < -49'sd32768) begin
            comp[k] = 16'h8000;
         end else begin
            comp[k] = rnd[15:0];
         end
      end
   end

   always_comb begin
      rsp_data_in.out_x      = comp[0];
      rsp_data_in.out_y      = comp[1];
      rsp_data_in.out_z      = comp[2];
      rsp_data_in.out_w      = comp[3];
      rsp_data_in.near_equal = p_side_ff.near;
   end

   assign out_free = !rsp_vld_ff || rsp_chan.ready;
   assign en       = out_free || !p_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (out_free) begin
         rsp_vld_ff <= p_vld_ff;
      end
      if (out_free) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign req_chan.ready = en;
   assign rsp_chan.valid = rsp_vld_ff;
   assign rsp_chan.data  = rsp_data_ff;

`ifndef SYNTHESIS
   // an empty result register never holds back the input
   assert property (@(posedge clock) disable iff (reset)
      !rsp_vld_ff |-> req_chan.ready)
      else $error("input stalled with an empty result register");

   // a result appears only from an occupied last stage
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_vld_ff) |-> $past(p_vld_ff))
      else $error("result raised without an item in the last stage");

   // a stalled pipeline holds its first stage
   assert property (@(posedge clock) disable iff (reset)
      (!en && !$past(reset)) |=> $stable(a_vld_ff))
      else $error("first stage changed during a stall");
`endif

endmodule
